/* rtl/core/kpc_pkg.sv */
`default_nettype none

package kpc_pkg;

	localparam int unsigned SCAN_W       = 8;
	localparam int unsigned KEY_W        = 3;
	localparam int unsigned NUM_CFG_REGS = 6;
	localparam int unsigned CFG_IDX_W    = 3;
	localparam int unsigned CMD_W        = 4;
	localparam int unsigned TICK_W       = 8;

	localparam int unsigned KPC_QUEUE_DEPTH = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_RUN   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STOP  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SET   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_UP    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DOWN  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ENTER = 3'd5;

	localparam logic [TICK_W-1:0] LONG_HOLD_LIMIT   = 8'd250;
	localparam logic [TICK_W-1:0] PRESS_LIMIT       = 8'd100;
	localparam logic [TICK_W-1:0] HOLD_RELOAD       = 8'd50;
	localparam logic [TICK_W-1:0] MIN_RELEASE_TICKS = 8'd5;

	typedef logic [KEY_W-1:0] key_idx_t;
	typedef key_idx_t [NUM_CFG_REGS-1:0] key_map_t;

	localparam key_map_t KEY_MAP_RESET = {3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0};

	typedef enum logic [CMD_W-1:0] {
		CMD_NONE      = 4'd0,
		CMD_RUN       = 4'd1,
		CMD_STOP      = 4'd2,
		CMD_SET       = 4'd3,
		CMD_UP        = 4'd4,
		CMD_DOWN      = 4'd5,
		CMD_ENTER     = 4'd6,
		CMD_RUN_REL   = 4'd7,
		CMD_STOP_REL  = 4'd8,
		CMD_SET_REL   = 4'd9,
		CMD_UP_REL    = 4'd10,
		CMD_DOWN_REL  = 4'd11,
		CMD_ENTER_REL = 4'd12
	} cmd_t;

	// decoded scan sample handed from front to back
	typedef struct packed {
		logic     key_valid;
		key_idx_t key;
		logic     refuse;
		logic     is_up;
		logic     is_down;
		cmd_t     press;
	} front_item_t;

	// first matching register wins: run, stop, set, up, down, enter
	function automatic cmd_t press_lookup(input key_idx_t key, input key_map_t kmap);
		cmd_t c;
		c = CMD_NONE;
		if (kmap[REG_RUN] == key)
			c = CMD_RUN;
		else if (kmap[REG_STOP] == key)
			c = CMD_STOP;
		else if (kmap[REG_SET] == key)
			c = CMD_SET;
		else if (kmap[REG_UP] == key)
			c = CMD_UP;
		else if (kmap[REG_DOWN] == key)
			c = CMD_DOWN;
		else if (kmap[REG_ENTER] == key)
			c = CMD_ENTER;
		return c;
	endfunction

	// release priority: run, stop, up, down, set, enter
	function automatic cmd_t release_lookup(input key_idx_t key, input key_map_t kmap);
		cmd_t c;
		c = CMD_NONE;
		if (kmap[REG_RUN] == key)
			c = CMD_RUN_REL;
		else if (kmap[REG_STOP] == key)
			c = CMD_STOP_REL;
		else if (kmap[REG_UP] == key)
			c = CMD_UP_REL;
		else if (kmap[REG_DOWN] == key)
			c = CMD_DOWN_REL;
		else if (kmap[REG_SET] == key)
			c = CMD_SET_REL;
		else if (kmap[REG_ENTER] == key)
			c = CMD_ENTER_REL;
		return c;
	endfunction

endpackage

`default_nettype wire

/* rtl/core/kpc_fifo.sv */
`default_nettype none

module kpc_fifo #(
	parameter int unsigned WIDTH = 4,
	parameter int unsigned DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rdata,
	output logic                  empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/kpc_front.sv */
`default_nettype none

module kpc_front (
	input  wire logic [kpc_pkg::SCAN_W-1:0] scan_byte_0,
	input  wire logic [kpc_pkg::SCAN_W-1:0] scan_byte_1,
	input  wire logic [kpc_pkg::SCAN_W-1:0] scan_byte_2,
	input  wire logic [kpc_pkg::SCAN_W-1:0] scan_byte_3,
	input  wire kpc_pkg::key_map_t          kmap,
	output kpc_pkg::front_item_t            item
);

	import kpc_pkg::*;

	logic [SCAN_W-1:0] merged;
	key_idx_t          key;

	// merge and cut to one byte
	assign merged = scan_byte_0
		| {scan_byte_1[SCAN_W-2:0], 1'b0}
		| {scan_byte_2[SCAN_W-3:0], 2'b0}
		| {scan_byte_3[SCAN_W-4:0], 3'b0};

	always_comb begin
		key = '0;
		for (int i = 0; i < SCAN_W; i++)
			if (merged[i])
				key = KEY_W'(i);
	end

	always_comb begin
		item.key_valid = $onehot(merged);
		item.key       = key;
		item.refuse    = (key == kmap[REG_RUN]) || (key == kmap[REG_STOP])
			|| (key == kmap[REG_SET]) || (key == kmap[REG_ENTER]);
		item.is_up     = (key == kmap[REG_UP]);
		item.is_down   = (key == kmap[REG_DOWN]);
		item.press     = press_lookup(key, kmap);
	end

endmodule

`default_nettype wire

/* rtl/core/kpc_back.sv */
`default_nettype none

module kpc_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire kpc_pkg::key_map_t    kmap,
	input  wire kpc_pkg::front_item_t item,
	input  wire logic                 item_valid,
	output logic                      item_pop,
	input  wire logic                 out_full,
	output logic                      out_push,
	output kpc_pkg::cmd_t             out_cmd
);

	import kpc_pkg::*;

	key_idx_t          last_key_q;
	logic [TICK_W-1:0] hold_ticks_q;
	logic              released_q;
	logic [TICK_W-1:0] long_hold_q;

	key_idx_t          last_key_d;
	logic [TICK_W-1:0] hold_ticks_d;
	logic              released_d;
	logic [TICK_W-1:0] long_hold_d;
	logic [TICK_W-1:0] hold_inc;
	cmd_t              cmd;

	assign item_pop = item_valid && !out_full;
	assign out_push = item_pop;
	assign out_cmd  = cmd;
	assign hold_inc = hold_ticks_q + 1'b1;

	always_comb begin
		cmd          = CMD_NONE;
		last_key_d   = last_key_q;
		hold_ticks_d = hold_ticks_q;
		released_d   = released_q;
		long_hold_d  = long_hold_q;
		if (item.key_valid) begin
			// refused keys leave the state untouched unless released_q is set
			if (released_q || !item.refuse) begin
				last_key_d   = item.key;
				hold_ticks_d = hold_inc;
				if (long_hold_q > LONG_HOLD_LIMIT) begin
					long_hold_d = '0;
					if (item.is_up)
						cmd = CMD_UP;
					else if (item.is_down)
						cmd = CMD_DOWN;
					released_d = (cmd == CMD_NONE);
				end else if (hold_inc > PRESS_LIMIT) begin
					hold_ticks_d = HOLD_RELOAD;
					long_hold_d  = long_hold_q + 1'b1;
					cmd          = item.press;
					released_d   = (item.press == CMD_NONE);
				end
			end
		end else begin
			released_d = 1'b1;
			if (hold_ticks_q < MIN_RELEASE_TICKS) begin
				hold_ticks_d = '0;
				last_key_d   = '0;
				long_hold_d  = '0;
			end else begin
				cmd = release_lookup(last_key_q, kmap);
			end
		end
		if (cmd != CMD_NONE) begin
			hold_ticks_d = '0;
			last_key_d   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_key_q   <= '0;
			hold_ticks_q <= '0;
			released_q   <= 1'b1;
			long_hold_q  <= '0;
		end else if (item_pop) begin
			last_key_q   <= last_key_d;
			hold_ticks_q <= hold_ticks_d;
			released_q   <= released_d;
			long_hold_q  <= long_hold_d;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/keypad_press_classifier_core.sv */
// Keypad press classifier: one key-scan sample in, one key command out.
//
// Input side is a queue write port: present scan_byte_0..3 with push; the
// sample transfers at a rising edge with push high and full low. Output
// side is a queue read port: while empty is low, key_command holds the
// oldest command; it transfers at a rising edge with pop high.
// Every sample yields exactly one command (zero when nothing happens).
//
// In an idle block a sample is written into the front queue, passes the
// back end into the output queue and then shows on key_command.
// One sample per cycle is sustained as long as pop keeps up; the single
// read-modify-write of the hold state in the back end sets that figure.
// A front queue and an output queue, each QUEUE_DEPTH deep, absorb a
// stalled reader; once both fill, full rises.
//
// Reset empties both queues, clears the hold state and loads the button
// map with run..enter on scan bits 0..5. Write cfg_we/cfg_index/cfg_data
// only while the block is idle; indexes 6 and 7 are ignored.
`default_nettype none

module keypad_press_classifier_core #(
	parameter int unsigned QUEUE_DEPTH = kpc_pkg::KPC_QUEUE_DEPTH
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         push,
	output logic                              full,
	input  wire logic [kpc_pkg::SCAN_W-1:0]   scan_byte_0,
	input  wire logic [kpc_pkg::SCAN_W-1:0]   scan_byte_1,
	input  wire logic [kpc_pkg::SCAN_W-1:0]   scan_byte_2,
	input  wire logic [kpc_pkg::SCAN_W-1:0]   scan_byte_3,
	output logic                              empty,
	input  wire logic                         pop,
	output logic      [kpc_pkg::CMD_W-1:0]    key_command,
	input  wire logic                         cfg_we,
	input  wire logic [kpc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [kpc_pkg::KEY_W-1:0]    cfg_data
);

	import kpc_pkg::*;

	localparam int unsigned ITEM_W = $bits(front_item_t);

	key_map_t          key_map_q;
	front_item_t       front_item;
	front_item_t       mid_item;
	logic [ITEM_W-1:0] mid_bits;
	logic              mid_empty;
	logic              mid_pop;
	logic              out_full;
	logic              out_push;
	cmd_t              out_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_map_q <= KEY_MAP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RUN, REG_STOP, REG_SET, REG_UP, REG_DOWN, REG_ENTER:
					key_map_q[cfg_index] <= cfg_data;
				default: ;
			endcase
		end
	end

	kpc_front u_front (
		.scan_byte_0 (scan_byte_0),
		.scan_byte_1 (scan_byte_1),
		.scan_byte_2 (scan_byte_2),
		.scan_byte_3 (scan_byte_3),
		.kmap        (key_map_q),
		.item        (front_item)
	);

	kpc_fifo #(
		.WIDTH (ITEM_W),
		.DEPTH (QUEUE_DEPTH)
	) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (front_item),
		.full   (full),
		.pop    (mid_pop),
		.rdata  (mid_bits),
		.empty  (mid_empty)
	);

	assign mid_item = front_item_t'(mid_bits);

	kpc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.kmap       (key_map_q),
		.item       (mid_item),
		.item_valid (!mid_empty),
		.item_pop   (mid_pop),
		.out_full   (out_full),
		.out_push   (out_push),
		.out_cmd    (out_cmd)
	);

	kpc_fifo #(
		.WIDTH (CMD_W),
		.DEPTH (QUEUE_DEPTH)
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.wdata  (out_cmd),
		.full   (out_full),
		.pop    (pop),
		.rdata  (key_command),
		.empty  (empty)
	);

endmodule

`default_nettype wire

/* rtl/core/kpc_checker.sv */
`default_nettype none

module kpc_checker (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      push,
	input wire logic                      full,
	input wire logic                      pop,
	input wire logic                      empty,
	input wire logic [kpc_pkg::CMD_W-1:0] key_command
);

	import kpc_pkg::*;

	// only defined command codes leave the block
	a_cmd_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (key_command <= CMD_ENTER_REL))
		else $error("undefined key command on output");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(key_command)))
		else $error("stalled command changed or vanished");

	// an accepted sample into an idle output reaches it via the front queue and back end
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full && empty) |-> ##2 !empty)
		else $error("command missing two cycles after transfer");

	// no command appears without a sample in flight
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		(empty && $past(empty) && !$past(push && !full)) |=> empty)
		else $error("command appeared without an input transfer");

endmodule

bind keypad_press_classifier_core kpc_checker u_kpc_checker (.*);

`default_nettype wire
